>>> rtl/core/glf_pkg.sv
// glf_pkg: shared constants, types and reset taps of the mirrored gaussian line filter
// no dependencies; imported by every module under rtl/core
package glf_pkg;

    localparam int RADIUS    = 3;
    localparam int WIN_LEN   = 2 * RADIUS + 1;
    localparam int NUM_TAPS  = RADIUS + 1;
    localparam int WIN_W     = $clog2(WIN_LEN);
    localparam int LAG_W     = $clog2(RADIUS + 1);

    localparam int SAMPLE_W  = 8;
    localparam int TAP_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int POS_W     = 4;
    localparam int MIR_W     = POS_W + 3;

    localparam int PAIR_W    = SAMPLE_W + 1;
    localparam int PROD_W    = PAIR_W + TAP_W;
    localparam int SUM_W     = PROD_W + LAG_W;

    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    // queue depths must be powers of two, pointers wrap naturally
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [POS_W-1:0]    POS_MAX = '1;
    localparam logic [SAMPLE_W-1:0] SAT_MAX = '1;

    typedef logic [WIN_LEN-1:0][SAMPLE_W-1:0] window_t;
    typedef logic [NUM_REGS-1:0][TAP_W-1:0]   tap_bank_t;

    // taps listed from distance seven down to the centre
    localparam tap_bank_t TAP_RESET = {
        17'd0, 17'd0, 17'd0, 17'd0,
        17'd291, 17'd3539, 17'd15862, 17'd26152
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                line_end;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic                line_last;
    } out_item_t;

    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] index;
        logic [TAP_W-1:0]     data;
    } cfg_write_t;

    // one queued item: window snapshot, its line index and the first lag to produce
    typedef struct packed {
        window_t          window;
        logic [POS_W-1:0] pos;
        logic [LAG_W-1:0] lag;
        logic             line_end;
    } job_t;

endpackage

>>> rtl/core/glf_front.sv
// glf_front: accepts samples, keeps the sample window and line position,
// and queues the items that produce filtered results; depends on glf_pkg
module glf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  glf_pkg::in_item_t item,
    input  logic             job_full,
    output logic             job_push,
    output glf_pkg::job_t    job
);
    import glf_pkg::*;

    window_t          window_reg;
    window_t          window_next;
    window_t          window_shift;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             accept;
    logic             past_lead;

    assign accept    = push & ~job_full;
    assign past_lead = pos_reg >= POS_W'(RADIUS);

    always_comb
    begin
        window_shift[0] = item.sample;
        for (int k = 1; k < WIN_LEN; k++)
        begin
            window_shift[k] = window_reg[k-1];
        end
    end

    always_comb
    begin
        window_next = window_reg;
        pos_next    = pos_reg;
        if (accept)
        begin
            window_next = window_shift;
            priority if (item.line_end)
                pos_next = '0;
            else if (pos_reg != POS_MAX)
                pos_next = pos_reg + 1'b1;
            else
                pos_next = pos_reg;
        end
    end

    always_comb
    begin
        job.window   = window_shift;
        job.pos      = pos_reg;
        job.line_end = item.line_end;
        // a line end flushes everything still pending, at most RADIUS+1 results
        if (item.line_end && !past_lead)
            job.lag = LAG_W'(pos_reg);
        else
            job.lag = LAG_W'(RADIUS);
    end

    assign job_push = accept & (item.line_end | past_lead);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

>>> rtl/core/glf_job_fifo.sv
// glf_job_fifo: short queue of pending filter jobs between front and back
// depends on glf_pkg
module glf_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  glf_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output glf_pkg::job_t dout,
    output logic          empty
);
    import glf_pkg::*;

    job_t                 mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_CNT_W-1:0] count_reg;
    logic [JOB_CNT_W-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = count_reg == JOB_CNT_W'(JOB_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end

endmodule

>>> rtl/core/glf_back.sv
// glf_back: tap registers, per-job result sequencer, three-step filter datapath
// (mirror select and pre-add, products, sum and saturate) and result queue; depends on glf_pkg
module glf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  glf_pkg::cfg_write_t cfg,
    input  glf_pkg::job_t       job,
    input  logic                job_empty,
    output logic                job_pop,
    input  logic                pop,
    output logic                empty,
    output glf_pkg::out_item_t  result
);
    import glf_pkg::*;

    tap_bank_t            tap_reg;

    logic [LAG_W-1:0]     step_reg;
    logic [LAG_W-1:0]     step_next;
    logic [LAG_W-1:0]     cur_lag;
    logic                 job_done;
    logic                 issue;
    logic                 issue_last;
    logic [RES_CNT_W-1:0] pending;
    logic                 credit_ok;

    logic [PAIR_W-1:0]    pair [NUM_TAPS];
    logic [PAIR_W-1:0]    s1_pair_reg [NUM_TAPS];
    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic [PROD_W-1:0]    s2_prod_reg [NUM_TAPS];
    logic                 s2_valid_reg;
    logic                 s2_last_reg;

    logic [SUM_W-1:0]        acc;
    logic [SUM_W-FRAC_W-1:0] scaled;
    out_item_t               res_item;

    out_item_t            res_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_ptr_reg;
    logic [RES_PTR_W-1:0] res_rd_ptr_reg;
    logic [RES_CNT_W-1:0] res_count_reg;
    logic [RES_CNT_W-1:0] res_count_next;
    logic                 res_pop;

    // sample weighted at offset d, taken at its line index mirrored and clamped into the line
    function automatic logic [SAMPLE_W-1:0] pick(
        input window_t          w,
        input logic [POS_W-1:0] p,
        input logic [LAG_W-1:0] lag,
        input int               d
    );
        logic signed [MIR_W-1:0] ps;
        logic signed [MIR_W-1:0] x;
        logic signed [MIR_W-1:0] k;
        ps = MIR_W'(p);
        x  = ps - MIR_W'(lag) + MIR_W'(d);
        if (x < 0)
            x = -x;
        if (x > ps)
            x = (ps <<< 1) - x;
        if (x < 0)
            x = '0;
        if (x > ps)
            x = ps;
        k = ps - x;
        if (k < WIN_LEN)
            pick = w[k[WIN_W-1:0]];
        else
            pick = '0;
    endfunction

    // tap registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tap_reg <= TAP_RESET;
        else if (cfg.we)
            tap_reg[cfg.index] <= cfg.data;
    end

    // sequencer: one filter evaluation per cycle from the head job while the result queue has room
    assign pending   = res_count_reg + RES_CNT_W'(s1_valid_reg) + RES_CNT_W'(s2_valid_reg);
    assign credit_ok = pending < RES_CNT_W'(RES_DEPTH);
    assign cur_lag   = job.lag - step_reg;
    assign job_done  = ~job.line_end | (cur_lag == '0);
    assign issue     = ~job_empty & credit_ok;
    assign issue_last = job.line_end & (cur_lag == '0);
    assign job_pop   = issue & job_done;

    always_comb
    begin
        step_next = step_reg;
        if (issue)
        begin
            if (job_done)
                step_next = '0;
            else
                step_next = step_reg + 1'b1;
        end
    end

    // symmetric taps: samples at +j and -j share a weight and are added first
    always_comb
    begin
        pair[0] = PAIR_W'(pick(job.window, job.pos, cur_lag, 0));
        for (int j = 1; j < NUM_TAPS; j++)
        begin
            pair[j] = PAIR_W'(pick(job.window, job.pos, cur_lag, -j))
                    + PAIR_W'(pick(job.window, job.pos, cur_lag, j));
        end
    end

    always_comb
    begin
        acc = '0;
        for (int j = 0; j < NUM_TAPS; j++)
        begin
            acc = acc + SUM_W'(s2_prod_reg[j]);
        end
        scaled = acc[SUM_W-1:FRAC_W];
        if (|scaled[SUM_W-FRAC_W-1:SAMPLE_W])
            res_item.filtered = SAT_MAX;
        else
            res_item.filtered = scaled[SAMPLE_W-1:0];
        res_item.line_last = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= issue_last;
        s2_last_reg <= s1_last_reg;
        for (int j = 0; j < NUM_TAPS; j++)
        begin
            s1_pair_reg[j] <= pair[j];
            s2_prod_reg[j] <= PROD_W'(s1_pair_reg[j]) * PROD_W'(tap_reg[j]);
        end
    end

    // result queue, room reserved at issue time
    assign empty   = res_count_reg == '0;
    assign res_pop = pop & ~empty;
    assign result  = res_mem[res_rd_ptr_reg];

    always_comb
    begin
        res_count_next = res_count_reg;
        if (s2_valid_reg && !res_pop)
            res_count_next = res_count_reg + 1'b1;
        else if (res_pop && !s2_valid_reg)
            res_count_next = res_count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            if (s2_valid_reg)
                res_wr_ptr_reg <= res_wr_ptr_reg + 1'b1;
            if (res_pop)
                res_rd_ptr_reg <= res_rd_ptr_reg + 1'b1;
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            res_mem[res_wr_ptr_reg] <= res_item;
    end

endmodule

>>> rtl/core/gaussian_line_filter_mirror.sv
// gaussian_line_filter_mirror: top level of the mirrored symmetric line filter
// depends on glf_pkg, glf_front, glf_job_fifo and glf_back
//
// input queue side: drive item and push; a transaction completes on a rising edge with
// push high and full low. line_end marks the final sample of a line.
// result side: while empty is low the oldest result sits on result; a transaction
// completes on a rising edge with pop high and empty low. line_last marks the final
// filtered sample of a line.
// tap write port: wr_en, wr_index, wr_data; writes take effect at once, no read-back.
// write taps only while the block is idle.
// a sample's job passes the job queue, the pair and product registers, then the result
// queue. throughput: one sample per cycle along a line while full is low; a line-end
// sample yields up to RADIUS+1 results, one per cycle from the shared datapath while the
// result queue has room, so input stalls once the job queue fills. a four-deep job queue
// sits between the front and that datapath. when pop stays low the four-deep result queue
// fills, issue stops, the job queue fills and full rises; nothing is lost.
// reset: taps return to their default gaussian, window and line position clear, both
// queues empty.
module gaussian_line_filter_mirror (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  glf_pkg::in_item_t             item,
    output logic                          empty,
    input  logic                          pop,
    output glf_pkg::out_item_t            result,
    input  logic                          wr_en,
    input  logic [glf_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [glf_pkg::TAP_W-1:0]     wr_data
);
    import glf_pkg::*;

    job_t       front_job;
    job_t       head_job;
    logic       job_push;
    logic       job_full;
    logic       job_pop;
    logic       job_empty;
    cfg_write_t cfg;

    assign cfg.we    = wr_en;
    assign cfg.index = wr_index;
    assign cfg.data  = wr_data;
    assign full      = job_full;

    glf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .job_full (job_full),
        .job_push (job_push),
        .job      (front_job)
    );

    glf_job_fifo u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (front_job),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (head_job),
        .empty (job_empty)
    );

    glf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job       (head_job),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
